@@ src/plel_pkg.sv @@
// Shared types and constants for the positional linked list engine.
// Holds operation and status codes, field widths and the store write-enable group.
// No dependencies.
package plel_pkg;

  // Field widths of the stream payloads
  localparam int ACTION_W   = 3;
  localparam int POS_W      = 8;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int LEN_W      = 7;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  // Operation codes
  localparam logic [ACTION_W-1:0] ACT_INSERT   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_DELETE   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_REVERSE  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_TRAVERSE = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // Write enables into the element and link memories
  typedef struct packed {
    logic elem;
    logic link;
  } store_we_t;

endpackage

@@ src/plel_store.sv @@
// Element and link memories of the linked list engine, one shared read address.
// Both memories read synchronously into registered outputs; each has its own write port.
// Depends on plel_pkg.
module plel_store #(
  parameter int DEPTH  = 64,
  parameter int SLOT_W = 6,
  parameter int ELEM_W = 32
) (
  input  logic                  clk,
  input  logic [SLOT_W-1:0]     raddr,
  input  plel_pkg::store_we_t   we,
  input  logic [SLOT_W-1:0]     elem_waddr,
  input  logic [ELEM_W-1:0]     elem_wdata,
  input  logic [SLOT_W-1:0]     link_waddr,
  input  logic [SLOT_W-1:0]     link_wdata,
  output logic [ELEM_W-1:0]     elem_rdata,
  output logic [SLOT_W-1:0]     link_rdata
);

  logic [ELEM_W-1:0] elem_mem [DEPTH];
  logic [SLOT_W-1:0] link_mem [DEPTH];

  // Write ports
  always_ff @(posedge clk) begin
    if (we.elem) begin
      elem_mem[elem_waddr] <= elem_wdata;
    end
    if (we.link) begin
      link_mem[link_waddr] <= link_wdata;
    end
  end

  // Registered read at the shared address
  always_ff @(posedge clk) begin
    elem_rdata <= elem_mem[raddr];
    link_rdata <= link_mem[raddr];
  end

endmodule

@@ src/positional_linked_list_engine_core.sv @@
// Positional linked list engine: an ordered list of up to CAPACITY elements kept
// in an element memory and a link memory, with a free-slot map and head pointer.
// An operation follows one link per cycle, set by the single read port of the link
// memory, between an accept step and a response step; a traversal holds its walk
// while the result side stalls, and a stalled result side stretches any operation.
// Clear, a short reverse, an empty traverse, a rejected request and an insert at
// position 1 follow no links; the worst case is a delete at position CAPACITY.
// A new transaction is taken once the previous one has placed its last result in the
// output register.
// Depends on plel_pkg and plel_store.
module positional_linked_list_engine_core #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: action[2:0], position[10:3], value[42:11], zero fill
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [plel_pkg::IN_TDATA_W-1:0]     in_tdata,
  // out_tdata: status[1:0], has_value[2], element[34:3], list_length[41:35], zero fill
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [plel_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tlast
);

  localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int ELEM_W = (DATA_WIDTH < plel_pkg::VALUE_W) ? DATA_WIDTH : plel_pkg::VALUE_W;
  localparam logic [plel_pkg::LEN_W-1:0] CAP_LEN = plel_pkg::LEN_W'(CAPACITY);

  // Sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_WALK     = 3'd1;
  localparam logic [2:0] S_INS_LINK = 3'd2;
  localparam logic [2:0] S_REV      = 3'd3;
  localparam logic [2:0] S_TRV      = 3'd4;
  localparam logic [2:0] S_RESP     = 3'd5;

  // Input fields
  logic [plel_pkg::ACTION_W-1:0] in_action;
  logic [plel_pkg::POS_W-1:0]    in_position;
  logic [plel_pkg::VALUE_W-1:0]  in_value;

  assign in_action   = in_tdata[2:0];
  assign in_position = in_tdata[10:3];
  assign in_value    = in_tdata[42:11];

  // Registers
  logic [2:0]                     state_r,      state_nxt;
  logic [SLOT_W-1:0]              rd_addr_r,    rd_addr_nxt;
  logic [SLOT_W-1:0]              prev_r,       prev_nxt;
  logic                           head_r,       head_nxt;
  logic                           is_del_r,     is_del_nxt;
  logic [plel_pkg::LEN_W-1:0]     rem_r,        rem_nxt;
  logic [SLOT_W-1:0]              first_r,      first_nxt;
  logic [plel_pkg::LEN_W-1:0]     count_r,      count_nxt;
  logic [CAPACITY-1:0]            free_map_r,   free_map_nxt;
  logic [SLOT_W-1:0]              free_slot_r,  free_slot_nxt;
  logic [plel_pkg::STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic                           res_hv_r,     res_hv_nxt;
  logic [plel_pkg::VALUE_W-1:0]   res_elem_r,   res_elem_nxt;
  logic                           out_tvalid_r;
  logic [plel_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic                           out_tlast_r;

  // Store interface
  logic [SLOT_W-1:0]    mem_raddr;
  plel_pkg::store_we_t  mem_we;
  logic [SLOT_W-1:0]    elem_waddr;
  logic [ELEM_W-1:0]    elem_wdata;
  logic [SLOT_W-1:0]    link_waddr;
  logic [SLOT_W-1:0]    link_wdata;
  logic [ELEM_W-1:0]    elem_rdata;
  logic [SLOT_W-1:0]    link_rdata;

  // Output load
  logic                           out_free;
  logic                           out_load;
  logic [plel_pkg::STATUS_W-1:0]  out_status;
  logic                           out_hv;
  logic [plel_pkg::VALUE_W-1:0]   out_elem;
  logic                           out_last;

  logic [plel_pkg::POS_W:0]       pos_ext;
  logic [plel_pkg::POS_W:0]       cnt_ext;

  plel_store #(
    .DEPTH  (CAPACITY),
    .SLOT_W (SLOT_W),
    .ELEM_W (ELEM_W)
  ) u_store (
    .clk        (clk),
    .raddr      (mem_raddr),
    .we         (mem_we),
    .elem_waddr (elem_waddr),
    .elem_wdata (elem_wdata),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .elem_rdata (elem_rdata),
    .link_rdata (link_rdata)
  );

  // Find the lowest free slot
  always_comb begin
    free_slot_nxt = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_map_r[i]) begin
        free_slot_nxt = SLOT_W'(i);
      end
    end
  end

  assign out_free = !out_tvalid_r || out_tready;
  assign pos_ext  = {1'b0, in_position};
  assign cnt_ext  = (plel_pkg::POS_W + 1)'(count_r);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    rd_addr_nxt    = rd_addr_r;
    prev_nxt       = prev_r;
    head_nxt       = head_r;
    is_del_nxt     = is_del_r;
    rem_nxt        = rem_r;
    first_nxt      = first_r;
    count_nxt      = count_r;
    free_map_nxt   = free_map_r;
    res_status_nxt = res_status_r;
    res_hv_nxt     = res_hv_r;
    res_elem_nxt   = res_elem_r;

    mem_raddr  = rd_addr_r;
    mem_we     = '0;
    elem_waddr = free_slot_r;
    elem_wdata = in_value[ELEM_W-1:0];
    link_waddr = rd_addr_r;
    link_wdata = free_slot_r;

    out_load   = 1'b0;
    out_status = res_status_r;
    out_hv     = res_hv_r;
    out_elem   = res_elem_r;
    out_last   = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        // Start the head read at once so a walk finds its data next cycle
        mem_raddr = first_r;
        if (in_tvalid) begin
          res_status_nxt = plel_pkg::ST_OK;
          res_hv_nxt     = 1'b0;
          res_elem_nxt   = '0;
          state_nxt      = S_RESP;
          unique case (in_action)
            plel_pkg::ACT_INSERT: begin
              if (in_position == '0 || pos_ext > cnt_ext + 9'd1) begin
                res_status_nxt = plel_pkg::ST_BAD_POS;
              end else if (count_r == CAP_LEN) begin
                res_status_nxt = plel_pkg::ST_FULL;
              end else begin
                mem_we.elem = 1'b1;
                if (in_position == plel_pkg::POS_W'(1)) begin
                  // Link in front of the head
                  mem_we.link  = 1'b1;
                  link_waddr   = free_slot_r;
                  link_wdata   = first_r;
                  first_nxt    = free_slot_r;
                  free_map_nxt[free_slot_r] = 1'b0;
                  count_nxt    = count_r + 1'b1;
                end else begin
                  rd_addr_nxt = first_r;
                  rem_nxt     = plel_pkg::LEN_W'(in_position - plel_pkg::POS_W'(2));
                  is_del_nxt  = 1'b0;
                  state_nxt   = S_WALK;
                end
              end
            end
            plel_pkg::ACT_DELETE: begin
              if (in_position == '0 || pos_ext > cnt_ext) begin
                res_status_nxt = plel_pkg::ST_BAD_POS;
              end else begin
                rd_addr_nxt = first_r;
                head_nxt    = 1'b1;
                rem_nxt     = plel_pkg::LEN_W'(in_position - plel_pkg::POS_W'(1));
                is_del_nxt  = 1'b1;
                state_nxt   = S_WALK;
              end
            end
            plel_pkg::ACT_REVERSE: begin
              if (count_r > plel_pkg::LEN_W'(1)) begin
                rd_addr_nxt = first_r;
                rem_nxt     = count_r - 1'b1;
                state_nxt   = S_REV;
              end
            end
            plel_pkg::ACT_TRAVERSE: begin
              if (count_r != '0) begin
                rd_addr_nxt = first_r;
                rem_nxt     = count_r - 1'b1;
                state_nxt   = S_TRV;
              end
            end
            plel_pkg::ACT_CLEAR: begin
              free_map_nxt = '1;
              count_nxt    = '0;
            end
            default: ;
          endcase
        end
      end

      S_WALK: begin
        // Follow one link per cycle
        mem_raddr = link_rdata;
        if (rem_r != '0) begin
          prev_nxt    = rd_addr_r;
          head_nxt    = 1'b0;
          rd_addr_nxt = link_rdata;
          rem_nxt     = rem_r - 1'b1;
        end else if (is_del_r) begin
          // Unlink the slot just read and return its value
          if (head_r) begin
            first_nxt = link_rdata;
          end else begin
            mem_we.link = 1'b1;
            link_waddr  = prev_r;
            link_wdata  = link_rdata;
          end
          free_map_nxt[rd_addr_r] = 1'b1;
          count_nxt    = count_r - 1'b1;
          res_hv_nxt   = 1'b1;
          res_elem_nxt = plel_pkg::VALUE_W'(elem_rdata);
          state_nxt    = S_RESP;
        end else begin
          // New slot takes over the successor of its predecessor
          mem_we.link = 1'b1;
          link_waddr  = free_slot_r;
          link_wdata  = link_rdata;
          state_nxt   = S_INS_LINK;
        end
      end

      S_INS_LINK: begin
        // Point the predecessor at the new slot
        mem_we.link = 1'b1;
        link_waddr  = rd_addr_r;
        link_wdata  = free_slot_r;
        free_map_nxt[free_slot_r] = 1'b0;
        count_nxt   = count_r + 1'b1;
        state_nxt   = S_RESP;
      end

      S_REV: begin
        // Read the successor while turning the current link backward
        mem_raddr   = link_rdata;
        mem_we.link = 1'b1;
        link_waddr  = rd_addr_r;
        link_wdata  = prev_r;
        if (rem_r != '0) begin
          prev_nxt    = rd_addr_r;
          rd_addr_nxt = link_rdata;
          rem_nxt     = rem_r - 1'b1;
        end else begin
          first_nxt = rd_addr_r;
          state_nxt = S_RESP;
        end
      end

      S_TRV: begin
        // Emit the element in hand; hold the read address while stalled
        if (out_free) begin
          mem_raddr  = link_rdata;
          out_load   = 1'b1;
          out_status = plel_pkg::ST_OK;
          out_hv     = 1'b1;
          out_elem   = plel_pkg::VALUE_W'(elem_rdata);
          out_last   = (rem_r == '0);
          if (rem_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            rd_addr_nxt = link_rdata;
            rem_nxt     = rem_r - 1'b1;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      first_r      <= '0;
      count_r      <= '0;
      free_map_r   <= '1;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      first_r    <= first_nxt;
      count_r    <= count_nxt;
      free_map_r <= free_map_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rd_addr_r    <= rd_addr_nxt;
    prev_r       <= prev_nxt;
    head_r       <= head_nxt;
    is_del_r     <= is_del_nxt;
    rem_r        <= rem_nxt;
    free_slot_r  <= free_slot_nxt;
    res_status_r <= res_status_nxt;
    res_hv_r     <= res_hv_nxt;
    res_elem_r   <= res_elem_nxt;
    if (out_load) begin
      out_tdata_r <= {6'b0, count_r, out_elem, out_hv, out_status};
      out_tlast_r <= out_last;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // Every slot is either free or linked into the list between operations
  a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ($countones(free_map_r) + int'(count_r) == CAPACITY))
    else $error("free map and element count disagree");

  // A traversal only runs over a non-empty list
  a_trv_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TRV) |-> (count_r != '0))
    else $error("traversal running on an empty list");

  // The element count never exceeds the store
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_LEN)
    else $error("element count above capacity");

endmodule

@@ verif/plel_list_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the positional linked list engine: keeps a slot-level model of the list,
// predicts every result of each accepted request and compares it with the output stream.
// Depends on plel_pkg.
module plel_list_checker #(
  parameter int CAPACITY = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: action[2:0], position[10:3], value[42:11], zero fill
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [plel_pkg::IN_TDATA_W-1:0]    in_tdata,
  // out_tdata: status[1:0], has_value[2], element[34:3], list_length[41:35], zero fill
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [plel_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               out_tlast,
  output int                                 error_count,
  output int                                 pending_count,
  output int                                 result_count,
  output int                                 list_length
);

  localparam logic [6:0] NIL_SLOT = 7'd127;

  typedef struct packed {
    logic [plel_pkg::STATUS_W-1:0] status;
    logic                          has_value;
    logic [plel_pkg::VALUE_W-1:0]  element;
    logic [plel_pkg::LEN_W-1:0]    length;
    logic                          is_last;
  } list_result_t;

  // Model of the list storage
  logic [plel_pkg::VALUE_W-1:0] elem_mem [0:63];
  logic [6:0]                   link_mem [0:63];
  logic [63:0]                  free_slots;
  logic [6:0]                   head_slot;
  int                           elem_total;

  list_result_t expected_results[$];
  int           fail_total    = 0;
  int           checked_total = 0;

  // Successor of a slot; the successor of the null marker is the head
  function automatic logic [6:0] next_slot(input logic [6:0] prev);
    if (prev == NIL_SLOT) return head_slot;
    return link_mem[prev[5:0]];
  endfunction

  task automatic link_after(input logic [6:0] prev, input logic [6:0] target);
    if (prev == NIL_SLOT) head_slot = target;
    else link_mem[prev[5:0]] = target;
  endtask

  // Slot that precedes 1-based position pos
  function automatic logic [6:0] slot_before(input int pos);
    logic [6:0] p;
    p = NIL_SLOT;
    for (int j = 1; j < pos; j++) p = next_slot(p);
    return p;
  endfunction

  task automatic queue_result(input logic [plel_pkg::STATUS_W-1:0] status,
                              input logic has_value,
                              input logic [plel_pkg::VALUE_W-1:0] element,
                              input logic is_last);
    list_result_t r;
    r.status    = status;
    r.has_value = has_value;
    r.element   = element;
    r.length    = elem_total[plel_pkg::LEN_W-1:0];
    r.is_last   = is_last;
    expected_results.push_back(r);
  endtask

  // Apply one request to the model and queue the results it causes
  task automatic predict_list_op(input logic [plel_pkg::ACTION_W-1:0] act,
                                 input logic [plel_pkg::POS_W-1:0] pos,
                                 input logic [plel_pkg::VALUE_W-1:0] val);
    logic [6:0] prev;
    logic [6:0] slot;
    logic [6:0] cur;
    logic [6:0] nxt;
    int         p;
    p = int'(pos);
    case (act)
      plel_pkg::ACT_INSERT: begin
        if (p < 1 || p > elem_total + 1) begin
          queue_result(plel_pkg::ST_BAD_POS, 1'b0, '0, 1'b1);
        end else if (elem_total >= CAPACITY) begin
          queue_result(plel_pkg::ST_FULL, 1'b0, '0, 1'b1);
        end else begin
          // take the lowest free slot
          slot = 7'd0;
          for (int k = CAPACITY - 1; k >= 0; k--) if (free_slots[k]) slot = 7'(k);
          prev = slot_before(p);
          free_slots[slot[5:0]] = 1'b0;
          elem_mem[slot[5:0]]   = val;
          link_mem[slot[5:0]]   = next_slot(prev);
          link_after(prev, slot);
          elem_total++;
          queue_result(plel_pkg::ST_OK, 1'b0, '0, 1'b1);
        end
      end
      plel_pkg::ACT_DELETE: begin
        if (p < 1 || p > elem_total) begin
          queue_result(plel_pkg::ST_BAD_POS, 1'b0, '0, 1'b1);
        end else begin
          prev = slot_before(p);
          cur  = next_slot(prev);
          link_after(prev, link_mem[cur[5:0]]);
          free_slots[cur[5:0]] = 1'b1;
          elem_total--;
          queue_result(plel_pkg::ST_OK, 1'b1, elem_mem[cur[5:0]], 1'b1);
        end
      end
      plel_pkg::ACT_REVERSE: begin
        prev = NIL_SLOT;
        cur  = head_slot;
        for (int k = 0; k < elem_total; k++) begin
          nxt = link_mem[cur[5:0]];
          link_mem[cur[5:0]] = prev;
          prev = cur;
          cur  = nxt;
        end
        if (elem_total > 0) head_slot = prev;
        queue_result(plel_pkg::ST_OK, 1'b0, '0, 1'b1);
      end
      plel_pkg::ACT_TRAVERSE: begin
        if (elem_total == 0) begin
          queue_result(plel_pkg::ST_OK, 1'b0, '0, 1'b1);
        end else begin
          cur = head_slot;
          for (int k = 0; k < elem_total; k++) begin
            queue_result(plel_pkg::ST_OK, 1'b1, elem_mem[cur[5:0]], k + 1 == elem_total);
            cur = link_mem[cur[5:0]];
          end
        end
      end
      plel_pkg::ACT_CLEAR: begin
        free_slots = '1;
        head_slot  = NIL_SLOT;
        elem_total = 0;
        queue_result(plel_pkg::ST_OK, 1'b0, '0, 1'b1);
      end
      default: begin
        // spare codes leave the list alone
        queue_result(plel_pkg::ST_OK, 1'b0, '0, 1'b1);
      end
    endcase
  endtask

  // Compare results first, then predict, so a result never meets its own request
  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (!rst_n) begin
      free_slots = '1;
      head_slot  = NIL_SLOT;
      elem_total = 0;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.status    = out_tdata[1:0];
        got.has_value = out_tdata[2];
        got.element   = out_tdata[34:3];
        got.length    = out_tdata[41:35];
        got.is_last   = out_tlast;
        if (expected_results.size() == 0) begin
          if (fail_total < 10)
            $display("%0t: unexpected result: st=%0d hv=%0b elem=%h len=%0d last=%0b",
                     $realtime, got.status, got.has_value, got.element, got.length,
                     got.is_last);
          fail_total++;
        end else begin
          want = expected_results.pop_front();
          checked_total++;
          if (got !== want) begin
            if (fail_total < 10) begin
              $display("%0t: mismatch, expected st=%0d hv=%0b elem=%h len=%0d last=%0b",
                       $realtime, want.status, want.has_value, want.element, want.length,
                       want.is_last);
              $display("%0t:             actual st=%0d hv=%0b elem=%h len=%0d last=%0b",
                       $realtime, got.status, got.has_value, got.element, got.length,
                       got.is_last);
            end
            fail_total++;
          end
        end
      end
      if (in_tvalid && in_tready)
        predict_list_op(in_tdata[2:0], in_tdata[10:3], in_tdata[42:11]);
    end
    error_count   <= fail_total;
    pending_count <= expected_results.size();
    result_count  <= checked_total;
    list_length   <= elem_total;
  end

endmodule

@@ verif/positional_linked_list_engine_core_tb.sv @@
`timescale 1ns / 100ps
// Top of the linked list engine testbench: clock, reset, request and result stream drivers,
// watchdog and verdict.
// Depends on plel_pkg, positional_linked_list_engine_core and plel_list_checker.
module positional_linked_list_engine_core_tb;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int TOTAL_OPS  = 230;
  localparam int QUIET_FROM = 205;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 80;

  // Action codes the block treats as no-ops
  localparam logic [plel_pkg::ACTION_W-1:0] ACT_SPARE_A = 3'd5;
  localparam logic [plel_pkg::ACTION_W-1:0] ACT_SPARE_B = 3'd6;
  localparam logic [plel_pkg::ACTION_W-1:0] ACT_SPARE_C = 3'd7;

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  // in_tdata: action[2:0], position[10:3], value[42:11], zero fill
  logic [plel_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                             out_tvalid;
  logic                             out_tready;
  // out_tdata: status[1:0], has_value[2], element[34:3], list_length[41:35], zero fill
  logic [plel_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tlast;

  int error_count;
  int pending_count;
  int result_count;
  int model_len;

  int ops_sent       = 0;
  int hold_requests  = 0;
  int holds_served   = 0;
  int quiet_cycles   = 0;
  int stall_cycles   = 0;
  logic quiet        = 1'b0;

  positional_linked_list_engine_core #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  plel_list_checker #(
    .CAPACITY (CAPACITY)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .error_count   (error_count),
    .pending_count (pending_count),
    .result_count  (result_count),
    .list_length   (model_len)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // End the run when no transaction moves for too long
  initial begin
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, pending_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Result side: random stall bursts, one long hold-off on request
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (holds_served < hold_requests) begin
        holds_served++;
        out_tready <= 1'b0;
        stall_cycles = 1;
        while (stall_cycles < HOLD_CYCLES) begin
          @(negedge clk);
          stall_cycles++;
        end
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one request; entered and left at a falling edge, valid stays high on exit
  task automatic send_op(input logic [plel_pkg::ACTION_W-1:0] act,
                         input logic [plel_pkg::POS_W-1:0] pos,
                         input logic [plel_pkg::VALUE_W-1:0] val);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(plel_pkg::IN_TDATA_W - plel_pkg::ACTION_W - plel_pkg::POS_W
                    - plel_pkg::VALUE_W){1'b0}}, val, pos, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    ops_sent++;
    @(negedge clk);
  endtask

  // Insert position: mostly in range, sometimes zero or anywhere beyond the end
  function automatic logic [plel_pkg::POS_W-1:0] insert_pos(input int len);
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1) == 0) return '0;
      return plel_pkg::POS_W'($urandom_range(len + 2, 255));
    end
    return plel_pkg::POS_W'($urandom_range(1, len + 1));
  endfunction

  function automatic logic [plel_pkg::POS_W-1:0] delete_pos(input int len);
    if (len == 0 || $urandom_range(0, 9) == 0) return plel_pkg::POS_W'($urandom_range(0, 255));
    return plel_pkg::POS_W'($urandom_range(1, len));
  endfunction

  // One random request from the working mix
  task automatic send_random_op();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)
      send_op(plel_pkg::ACT_INSERT, insert_pos(model_len), $urandom);
    else if (pick < 72)
      send_op(plel_pkg::ACT_DELETE, delete_pos(model_len), $urandom);
    else if (pick < 80)
      send_op(plel_pkg::ACT_TRAVERSE, plel_pkg::POS_W'($urandom_range(0, 255)), $urandom);
    else if (pick < 88)
      send_op(plel_pkg::ACT_REVERSE, plel_pkg::POS_W'($urandom_range(0, 255)), $urandom);
    else if (pick < 92)
      send_op(plel_pkg::ACT_CLEAR, plel_pkg::POS_W'($urandom_range(0, 255)), $urandom);
    else if (pick < 96)
      send_op(plel_pkg::ACTION_W'($urandom_range(ACT_SPARE_A, ACT_SPARE_C)),
              plel_pkg::POS_W'($urandom_range(0, 255)), $urandom);
    else
      send_op(plel_pkg::ACT_INSERT, plel_pkg::POS_W'(model_len + 1), $urandom);
  endtask

  initial begin
    int fill_ops;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty list corners, value extremes, bad positions, spare codes
    send_op(plel_pkg::ACT_TRAVERSE, 8'd0,   32'h0000_0000);
    send_op(plel_pkg::ACT_REVERSE,  8'd0,   32'h0000_0000);
    send_op(plel_pkg::ACT_DELETE,   8'd1,   32'h0000_0000);
    send_op(plel_pkg::ACT_INSERT,   8'd0,   32'h1234_5678);
    send_op(plel_pkg::ACT_INSERT,   8'd2,   32'h1234_5678);
    send_op(plel_pkg::ACT_INSERT,   8'd1,   32'h7fff_ffff);
    send_op(plel_pkg::ACT_REVERSE,  8'd0,   32'h0000_0000);
    send_op(plel_pkg::ACT_INSERT,   8'd1,   32'h8000_0000);
    send_op(plel_pkg::ACT_INSERT,   8'd3,   32'hffff_ffff);
    send_op(plel_pkg::ACT_INSERT,   8'd2,   32'h0000_0000);
    send_op(plel_pkg::ACT_INSERT,   8'd255, 32'hffff_ffff);
    send_op(plel_pkg::ACT_TRAVERSE, 8'd255, 32'hffff_ffff);
    send_op(plel_pkg::ACT_REVERSE,  8'd255, 32'h0000_0000);
    send_op(plel_pkg::ACT_TRAVERSE, 8'd0,   32'h0000_0000);
    send_op(plel_pkg::ACT_DELETE,   8'd0,   32'h0000_0000);
    send_op(plel_pkg::ACT_DELETE,   8'd5,   32'h0000_0000);
    send_op(plel_pkg::ACT_DELETE,   8'd4,   32'hffff_ffff);
    send_op(plel_pkg::ACT_DELETE,   8'd1,   32'h0000_0000);
    send_op(ACT_SPARE_A,            8'd255, 32'hffff_ffff);
    send_op(ACT_SPARE_B,            8'd0,   32'h0000_0000);
    send_op(ACT_SPARE_C,            8'd255, 32'ha5a5_5a5a);
    send_op(plel_pkg::ACT_TRAVERSE, 8'd0,   32'h0000_0000);
    send_op(plel_pkg::ACT_CLEAR,    8'd255, 32'hffff_ffff);
    send_op(plel_pkg::ACT_TRAVERSE, 8'd0,   32'h0000_0000);
    send_op(plel_pkg::ACT_INSERT,   8'd1,   32'h5555_5555);

    // Fill the store; hold the result side early so the block backs up
    fill_ops = 0;
    while (model_len < CAPACITY) begin
      if (fill_ops == 8) hold_requests++;
      send_op(plel_pkg::ACT_INSERT, insert_pos(model_len), $urandom);
      fill_ops++;
    end
    send_op(plel_pkg::ACT_INSERT, 8'd1, $urandom);
    send_op(plel_pkg::ACT_INSERT, plel_pkg::POS_W'(CAPACITY + 1), $urandom);
    send_op(plel_pkg::ACT_INSERT, plel_pkg::POS_W'(CAPACITY + 2), $urandom);
    send_op(plel_pkg::ACT_TRAVERSE, 8'd0, $urandom);
    send_op(plel_pkg::ACT_REVERSE, 8'd0, $urandom);
    send_op(plel_pkg::ACT_DELETE, plel_pkg::POS_W'(CAPACITY), $urandom);
    send_op(plel_pkg::ACT_DELETE, 8'd1, $urandom);

    // Working mix; the tail runs without idle cycles
    while (ops_sent < TOTAL_OPS) begin
      if (ops_sent >= QUIET_FROM) quiet = 1'b1;
      send_random_op();
    end
    in_tvalid <= 1'b0;

    // Drain, then allow for one more walk of the list
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d requests covering every action, bad positions and a full store",
             ops_sent);
    $display("Summary: %0d results checked, including one long result-side hold-off",
             result_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
